// ----- rtl/reb_pkg.sv -----
// Package for the rotary encoder button event block: event codes and
// configuration register indexes. No dependencies.
package reb_pkg;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_CLOCKWISE  = 3'd1,
      EV_COUNTER_CW = 3'd2,
      EV_CLICK      = 3'd3,
      EV_LONG_PRESS = 3'd4
   } event_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ENCODER_PRESENT = 3'd0,
      CSR_BUTTON_PRESENT  = 3'd1,
      CSR_LONG_PRESS      = 3'd2,
      CSR_CLICK_WINDOW    = 3'd3,
      CSR_DEBOUNCE        = 3'd4
   } csr_index_type;

   localparam logic [9:0]  CLICK_WINDOW_RESET = 10'd280;
   localparam logic [7:0]  DEBOUNCE_RESET     = 8'd5;
   localparam int          TALLY_WIDTH        = 8;
   localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = '1;

endpackage

// ----- rtl/rotary_encoder_button_events.sv -----
// Rotary encoder and push button event detector, one transfer per tick.
// Each input transfer's result is registered in the output register.
// Throughput: one item per cycle unless rsp_stall holds the output; the state update
// and result are one pass of compare/add, and the output refills while being drained.
// Reset (synchronous, active high) restores config defaults, tracking and rsp_valid.
// Depends on reb_pkg.
module rotary_encoder_button_events
   import reb_pkg::*;
#(
   parameter int POSITION_WIDTH = 16,
   parameter int TIME_WIDTH     = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // configuration write port
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   // input channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_clk_level,
   input  logic                       req_dt_level,
   input  logic                       req_sw_level,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_event_code,
   output logic signed [15:0]         rsp_position_now,
   output logic                       rsp_pressed_now
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic        encoder_present_ff;
   logic        button_present_ff;
   logic [15:0] long_press_ff;
   logic [9:0]  click_window_ff;
   logic [7:0]  debounce_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         encoder_present_ff <= 1'b1;
         button_present_ff  <= 1'b1;
         long_press_ff      <= '0;
         click_window_ff    <= CLICK_WINDOW_RESET;
         debounce_ff        <= DEBOUNCE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENCODER_PRESENT: encoder_present_ff <= csr_wdata[0];
            CSR_BUTTON_PRESENT:  button_present_ff  <= csr_wdata[0];
            CSR_LONG_PRESS:      long_press_ff      <= csr_wdata;
            CSR_CLICK_WINDOW:    click_window_ff    <= csr_wdata[9:0];
            CSR_DEBOUNCE:        debounce_ff        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Tracking state
   // ---------------------------------------------------------------
   logic [TIME_WIDTH-1:0]     tick_ff,        tick_in;
   logic                      prev_clk_ff,    prev_clk_in;
   logic [TIME_WIDTH-1:0]     last_edge_ff,   last_edge_in;
   logic [POSITION_WIDTH-1:0] position_ff,    position_in;
   logic                      btn_prev_ff,    btn_prev_in;
   logic                      press_valid_ff, press_valid_in;
   logic [TIME_WIDTH-1:0]     press_start_ff, press_start_in;
   logic [TALLY_WIDTH-1:0]    tally_ff,       tally_in;
   logic [TIME_WIDTH-1:0]     stamp_ff,       stamp_in;
   logic                      pending_ff,     pending_in;
   logic                      cancel_ff,      cancel_in;

   // output register
   logic                      rsp_valid_ff,   rsp_valid_in;
   event_type                 event_ff,       event_in;
   logic [15:0]               rsp_pos_ff,     rsp_pos_in;
   logic                      pressed_ff,     pressed_in;

   logic                      accept;
   logic [31:0]               position_ext;

   // Take a new item whenever the output register is empty or drains this cycle.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // ---------------------------------------------------------------
   // One tick of encoder and button processing
   // ---------------------------------------------------------------
   always_comb begin
      logic                  stepped;
      logic                  step_down;
      logic                  click;
      logic [TIME_WIDTH-1:0] now;
      logic [TIME_WIDTH-1:0] held;
      logic [TIME_WIDTH-1:0] waited;

      now            = tick_ff;
      tick_in        = tick_ff + TIME_WIDTH'(1);
      prev_clk_in    = prev_clk_ff;
      last_edge_in   = last_edge_ff;
      position_in    = position_ff;
      btn_prev_in    = btn_prev_ff;
      press_valid_in = press_valid_ff;
      press_start_in = press_start_ff;
      tally_in       = tally_ff;
      stamp_in       = stamp_ff;
      pending_in     = pending_ff;
      cancel_in      = cancel_ff;
      event_in       = EV_NONE;
      stepped        = 1'b0;
      step_down      = 1'b0;
      click          = 1'b0;
      held           = '0;
      waited         = '0;

      // Encoder: an accepted clock change restarts debounce; a falling clock steps.
      if (req_clk_level != prev_clk_ff) begin
         prev_clk_in = req_clk_level;
         if (encoder_present_ff &&
             (now - last_edge_ff) >= TIME_WIDTH'(debounce_ff)) begin
            last_edge_in = now;
            if (!req_clk_level) begin
               stepped   = 1'b1;
               step_down = req_dt_level;
            end
         end
      end

      if (stepped) begin
         // a single step always differs from the last reported position
         if (step_down) begin
            position_in = position_ff - POSITION_WIDTH'(1);
            event_in    = EV_COUNTER_CW;
         end else begin
            position_in = position_ff + POSITION_WIDTH'(1);
            event_in    = EV_CLOCKWISE;
         end
      end else if (button_present_ff) begin
         if (req_sw_level != btn_prev_ff) begin
            if (!req_sw_level) begin
               press_start_in = now;
               press_valid_in = 1'b1;
            end else begin
               held = now - press_start_ff;
               if (long_press_ff != '0) begin
                  click = press_valid_ff && (held < TIME_WIDTH'(long_press_ff));
               end else begin
                  click = 1'b1;
               end
               if (click) begin
                  if (tally_ff != TALLY_MAX) begin
                     tally_in = tally_ff + TALLY_WIDTH'(1);
                  end
                  stamp_in   = now;
                  pending_in = 1'b1;
               end
               if (cancel_ff) begin
                  tally_in   = '0;
                  stamp_in   = '0;
                  pending_in = 1'b0;
               end
               press_valid_in = 1'b0;
            end
            btn_prev_in = req_sw_level;
         end

         // release ends a cancelled press
         if (req_sw_level && cancel_in) begin
            cancel_in = 1'b0;
         end

         held = now - press_start_in;
         if ((long_press_ff != '0) && press_valid_in &&
             (held >= TIME_WIDTH'(long_press_ff))) begin
            if (pending_in) begin
               cancel_in = 1'b1;
            end else begin
               event_in = EV_LONG_PRESS;
            end
            press_valid_in = 1'b0;
            tally_in       = '0;
            stamp_in       = '0;
            pending_in     = 1'b0;
         end

         // Window expired: report a single click; hold it while a press is down.
         waited = now - stamp_in;
         if (pending_in && (waited >= TIME_WIDTH'(click_window_ff)) && !press_valid_in) begin
            if (tally_in == TALLY_WIDTH'(1)) begin
               event_in = EV_CLICK;
            end
            tally_in   = '0;
            stamp_in   = '0;
            pending_in = 1'b0;
         end
      end
   end

   assign position_ext = 32'(position_in);
   assign rsp_pos_in   = position_ext[15:0];
   assign pressed_in   = button_present_ff & ~req_sw_level;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff        <= '0;
         prev_clk_ff    <= 1'b1;
         last_edge_ff   <= '0;
         position_ff    <= '0;
         btn_prev_ff    <= 1'b1;
         press_valid_ff <= 1'b0;
         press_start_ff <= '0;
         tally_ff       <= '0;
         stamp_ff       <= '0;
         pending_ff     <= 1'b0;
         cancel_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            tick_ff        <= tick_in;
            prev_clk_ff    <= prev_clk_in;
            last_edge_ff   <= last_edge_in;
            position_ff    <= position_in;
            btn_prev_ff    <= btn_prev_in;
            press_valid_ff <= press_valid_in;
            press_start_ff <= press_start_in;
            tally_ff       <= tally_in;
            stamp_ff       <= stamp_in;
            pending_ff     <= pending_in;
            cancel_ff      <= cancel_in;
         end
      end
   end

   // Load the result payload on each input transfer; hold it while stalled.
   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff   <= event_in;
         rsp_pos_ff <= rsp_pos_in;
         pressed_ff <= pressed_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_code   = event_ff;
   assign rsp_position_now = rsp_pos_ff;
   assign rsp_pressed_now  = pressed_ff;

endmodule

// ----- rtl/reb_checker.sv -----
// Port-level checks for rotary_encoder_button_events, attached by bind.
// Depends on reb_pkg for the event codes.
module reb_checker
   import reb_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_event_code,
   input logic signed [15:0] rsp_position_now,
   input logic               rsp_pressed_now
);

   // every input transfer yields a result in the next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("input transfer without result");

   // input never stalls while the output register is empty
   a_no_stall_when_empty: assert property (@(posedge clock)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output register");

   // output register empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present after reset");

   // stalled result holds
   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_event_code) &&
         $stable(rsp_position_now) && $stable(rsp_pressed_now)))
      else $error("stalled result changed");

endmodule

bind rotary_encoder_button_events reb_checker u_reb_checker (.*);

// ----- sim/rotary_encoder_button_events_tb.sv -----
// Self-checking testbench for the rotary encoder and push button event block.
// Predicts every result from the sampled line levels and checks it field by field.
// Depends on reb_pkg and rotary_encoder_button_events.
module rotary_encoder_button_events_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import reb_pkg::*;

   localparam int DRAIN_CYCLES = 4;     // result register latency plus margin
   localparam int STALL_LIMIT  = 1000;  // cycles with no transfer before giving up
   localparam int LONG_HOLD    = 60;    // receiver hold-off that backs up the block
   localparam int HOLD_AT      = 400;   // result count at which that hold-off starts
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic clk;
      logic dt;
      logic sw;
   } tick_levels_type;

   typedef struct {
      event_type   code;
      logic [15:0] position;
      logic        pressed;
   } result_type;

   logic clock;
   logic reset = 1'b1;

   logic        csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   logic req_valid = 1'b0;
   logic req_stall;
   logic req_clk_level = 1'b1;
   logic req_dt_level = 1'b0;
   logic req_sw_level = 1'b1;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_code;
   logic signed [15:0] rsp_position_now;
   logic        rsp_pressed_now;

   rotary_encoder_button_events uut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_clk_level   (req_clk_level),
      .req_dt_level    (req_dt_level),
      .req_sw_level    (req_sw_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_code  (rsp_event_code),
      .rsp_position_now(rsp_position_now),
      .rsp_pressed_now (rsp_pressed_now)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Ticks waiting to be offered, and results the block still owes us.
   tick_levels_type pending_ticks[$];
   result_type      expected_results[$];

   // Register mirror, starting from the reset defaults.
   logic        cfg_encoder = 1'b1;
   logic        cfg_button = 1'b1;
   logic [15:0] cfg_long = 16'd0;
   logic [9:0]  cfg_window = CLICK_WINDOW_RESET;
   logic [7:0]  cfg_debounce = DEBOUNCE_RESET;

   // Predictor state, starting from the reset state of the block.
   logic [31:0] ticks_elapsed = '0;
   logic        clk_line_seen = 1'b1;
   logic [31:0] last_turn_tick = '0;
   logic [15:0] position = '0;
   logic [15:0] position_shown = '0;
   logic        sw_line_seen = 1'b1;
   logic        press_armed = 1'b0;
   logic [31:0] press_tick = '0;
   logic [7:0]  click_count = '0;
   logic [31:0] click_tick = '0;
   logic        click_waiting = 1'b0;
   logic        click_veto = 1'b0;

   int turn_events = 0;
   int click_events = 0;
   int long_press_events = 0;
   int error_count = 0;
   int result_count = 0;
   int cfg_settings = 0;

   // Stimulus generator state: the line levels currently being sampled.
   logic cur_clk = 1'b1;
   logic cur_dt = 1'b0;
   logic cur_sw = 1'b1;
   int   gen_count = 0;
   int   gen_target = 0;
   bit   traffic_gaps = 1'b1;

   function automatic logic [31:0] ticks_between(logic [31:0] now, logic [31:0] then);
      return now - then;
   endfunction

   function automatic void drop_clicks();
      click_count = '0;
      click_tick = '0;
      click_waiting = 1'b0;
   endfunction

   function automatic event_type button_step(logic sw, logic [31:0] now);
      event_type ev;
      logic      is_click;
      ev = EV_NONE;
      if (sw != sw_line_seen) begin
         if (!sw) begin
            press_tick = now;
            press_armed = 1'b1;
         end else begin
            // a release counts as a click unless the press already ran long
            if (cfg_long != 0)
               is_click = press_armed && (ticks_between(now, press_tick) < cfg_long);
            else
               is_click = 1'b1;
            if (is_click) begin
               if (click_count != TALLY_MAX) click_count++;
               click_tick = now;
               click_waiting = 1'b1;
            end
            if (click_veto) drop_clicks();
            press_armed = 1'b0;
         end
         sw_line_seen = sw;
      end
      if (sw && click_veto) click_veto = 1'b0;
      if (cfg_long != 0 && press_armed && ticks_between(now, press_tick) >= cfg_long) begin
         // a held press either reports itself or cancels a waiting click
         if (click_waiting)
            click_veto = 1'b1;
         else begin
            ev = EV_LONG_PRESS;
            long_press_events++;
         end
         press_armed = 1'b0;
         drop_clicks();
      end
      // an expired window waits while the switch is still held down
      if (click_waiting && ticks_between(now, click_tick) >= cfg_window && !press_armed) begin
         if (click_count == 1) begin
            ev = EV_CLICK;
            click_events++;
         end
         drop_clicks();
      end
      return ev;
   endfunction

   function automatic result_type predict_tick(tick_levels_type t);
      result_type  r;
      logic [31:0] now;
      logic [15:0] delta;
      now = ticks_elapsed;
      r.code = EV_NONE;
      if (t.clk != clk_line_seen) begin
         clk_line_seen = t.clk;
         if (cfg_encoder && ticks_between(now, last_turn_tick) >= cfg_debounce) begin
            last_turn_tick = now;
            if (!t.clk) position = t.dt ? position - 16'd1 : position + 16'd1;
         end
      end
      if (position != position_shown) begin
         // a rotation tick owns the event slot and skips the button
         delta = position - position_shown;
         r.code = delta[15] ? EV_COUNTER_CW : EV_CLOCKWISE;
         position_shown = position;
         turn_events++;
      end else if (cfg_button) begin
         r.code = button_step(t.sw, now);
      end
      ticks_elapsed = ticks_elapsed + 32'd1;
      r.position = position;
      r.pressed = cfg_button && !t.sw;
      return r;
   endfunction

   // Driver: offer the head of the tick queue, hold it while stalled, and
   // predict each tick at the edge where its transfer happens.
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_tick(pending_ticks.pop_front()));
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_ticks.size() == 0) begin
               req_valid <= 1'b0;
            end else if (traffic_gaps && $urandom_range(0, 7) == 0) begin
               // idle burst, this cycle included, that send_gap extends at random
               send_gap = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_clk_level <= pending_ticks[0].clk;
               req_dt_level <= pending_ticks[0].dt;
               req_sw_level <= pending_ticks[0].sw;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest prediction and
   // pick the stall for the next cycle.
   int  stall_left = 0;
   bit  long_hold_done = 1'b0;

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("result %0d: arrived with nothing outstanding", result_count);
            end else begin
               want = expected_results.pop_front();
               if (rsp_event_code !== want.code || rsp_position_now !== want.position ||
                   rsp_pressed_now !== want.pressed) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("result %0d: expected event %0d position %0d pressed %0b",
                              result_count, want.code, $signed(want.position),
                              want.pressed);
                     $display("   got event %0d position %0d pressed %0b",
                              rsp_event_code, rsp_position_now, rsp_pressed_now);
                  end
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && result_count >= HOLD_AT) begin
            // hold off long enough for the block to back up into its input
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else if (traffic_gaps && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: count cycles without any transfer on either channel.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("no transfer for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, expected_results.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_tick();
      tick_levels_type t;
      if (gen_count < gen_target) begin
         t.clk = cur_clk;
         t.dt = cur_dt;
         t.sw = cur_sw;
         pending_ticks.push_back(t);
         gen_count++;
      end
   endtask

   task automatic hold_ticks(int n);
      repeat (n) push_tick();
   endtask

   task automatic put(logic clk, logic dt, logic sw);
      cur_clk = clk;
      cur_dt = dt;
      cur_sw = sw;
      push_tick();
   endtask

   // One detent: clock line low then high, each held around the debounce time
   // so that some changes land inside the interval and get dropped.
   task automatic turn_detent(logic dir);
      cur_dt = dir;
      cur_clk = 1'b0;
      hold_ticks($urandom_range(1, cfg_debounce + 2));
      cur_clk = 1'b1;
      hold_ticks($urandom_range(1, cfg_debounce + 2));
   endtask

   // Quiet time after a release: mostly short, now and then past the click window.
   function automatic int click_gap();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, cfg_window + 3)
                                         : $urandom_range(0, 8);
   endfunction

   task automatic queue_random_ticks(int count);
      int pick;
      int span;
      gen_count = 0;
      gen_target = count;
      while (gen_count < gen_target) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3: begin
               turn_detent(1'($urandom_range(0, 1)));
            end
            4, 5, 6: begin
               // press of random length, past the long-press time when that is short, maybe turning
               span = (cfg_long != 0 && cfg_long < 40) ? cfg_long + 3 : 12;
               cur_sw = 1'b0;
               hold_ticks($urandom_range(1, span));
               if ($urandom_range(0, 2) == 0) turn_detent(1'($urandom_range(0, 1)));
               cur_sw = 1'b1;
               hold_ticks(click_gap());
            end
            7: begin
               // double click, which the block drops unreported when both fall inside the window
               repeat (2) begin
                  cur_sw = 1'b0;
                  hold_ticks($urandom_range(1, 3));
                  cur_sw = 1'b1;
                  hold_ticks($urandom_range(1, 3));
               end
               hold_ticks(click_gap());
            end
            8: begin
               repeat ($urandom_range(1, 3))
                  put(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            end
            default: begin
               hold_ticks($urandom_range(1, 10));
            end
         endcase
      end
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_ENCODER_PRESENT: cfg_encoder = data[0];
         CSR_BUTTON_PRESENT:  cfg_button = data[0];
         CSR_LONG_PRESS:      cfg_long = data;
         CSR_CLICK_WINDOW:    cfg_window = data[9:0];
         CSR_DEBOUNCE:        cfg_debounce = data[7:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic enc, logic btn, logic [15:0] long_len,
                            logic [9:0] window, logic [7:0] debounce);
      write_reg(CSR_ENCODER_PRESENT, {15'd0, enc});
      write_reg(CSR_BUTTON_PRESENT, {15'd0, btn});
      write_reg(CSR_LONG_PRESS, long_len);
      write_reg(CSR_CLICK_WINDOW, {6'd0, window});
      write_reg(CSR_DEBOUNCE, {8'd0, debounce});
      csr_we <= 1'b0;
      cfg_settings++;
   endtask

   // Wait until every tick has gone through and every result has come back.
   task automatic drain();
      do @(posedge clock);
      while (pending_ticks.size() != 0 || expected_results.size() != 0 || req_valid ||
             rsp_valid);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: clock changes in the first ticks are ignored, then one
      // detent each way; the press lands on a rotation tick and is skipped.
      gen_count = 0;
      gen_target = 1 << 30;
      put(1'b1, 1'b0, 1'b1);
      put(1'b0, 1'b0, 1'b1);
      put(1'b1, 1'b0, 1'b1);
      put(1'b1, 1'b0, 1'b1);
      put(1'b1, 1'b0, 1'b1);
      put(1'b0, 1'b0, 1'b1);
      put(1'b1, 1'b0, 1'b1);
      put(1'b1, 1'b1, 1'b1);
      put(1'b1, 1'b1, 1'b1);
      put(1'b1, 1'b1, 1'b1);
      put(1'b0, 1'b1, 1'b0);
      queue_random_ticks(250);
      drain();

      // Short times: click after release, a second press held across the
      // window that then cancels the click, and a plain long press.
      configure(1'b1, 1'b1, 16'd4, 10'd2, 8'd1);
      gen_count = 0;
      gen_target = 1 << 30;
      put(1'b1, 1'b0, 1'b0);
      put(1'b1, 1'b0, 1'b1);
      repeat (5) put(1'b1, 1'b0, 1'b0);
      put(1'b1, 1'b0, 1'b1);
      repeat (5) put(1'b1, 1'b0, 1'b0);
      put(1'b1, 1'b0, 1'b1);
      queue_random_ticks(300);
      drain();

      configure(1'b1, 1'b1, 16'd12, 10'd9, 8'd3);
      queue_random_ticks(200);
      drain();

      // Encoder off, fastest possible button timing, no idling on either side.
      traffic_gaps = 1'b0;
      configure(1'b0, 1'b1, 16'd1, 10'd0, 8'd0);
      queue_random_ticks(150);
      drain();

      // Longest times the registers allow.
      traffic_gaps = 1'b1;
      configure(1'b1, 1'b1, 16'hFFFF, 10'h3FF, 8'hFF);
      queue_random_ticks(250);
      drain();

      configure(1'b1, 1'b0, 16'd20, 10'd30, 8'd2);
      queue_random_ticks(100);
      drain();

      // Fast turning with no debounce and the button absent. Run it without
      // idling on either side.
      traffic_gaps = 1'b0;
      configure(1'b1, 1'b0, 16'd0, 10'd0, 8'd0);
      gen_count = 0;
      gen_target = 1 << 30;
      cur_sw = 1'($urandom_range(0, 1));
      put(1'b1, 1'b0, cur_sw);
      repeat (15) turn_detent(1'($urandom_range(0, 1)));
      drain();

      $display("checked %0d ticks over %0d register settings plus the reset defaults",
               result_count, cfg_settings);
      $display("saw %0d rotation events, %0d clicks and %0d long presses",
               turn_events, click_events, long_press_events);
      if (error_count == 0 && expected_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
